// ===== sv/pid_regulator_top_macros.svh =====
// Assertion macros used by the checker file.
`ifndef PID_REGULATOR_TOP_MACROS_SVH
`define PID_REGULATOR_TOP_MACROS_SVH

// Same-cycle implication, quiet while reset is held.
`define PRG_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pid_regulator: same-cycle check failed");

// Next-cycle implication, quiet while reset is held.
`define PRG_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pid_regulator: next-cycle check failed");

// Next-cycle implication that is also checked across reset.
`define PRG_ASSERT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("pid_regulator: reset check failed");

`endif

// ===== sv/pid_reg_pkg.sv =====
`timescale 1ns / 1ps

package pid_reg_pkg;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 16;
    localparam int BOUND_W  = 23;
    localparam int ERR_W    = SAMPLE_W + 1;
    localparam int SUM_W    = 24;
    localparam int CAND_W   = SUM_W + 1;
    localparam int PD_W     = GAIN_W + ERR_W;
    localparam int PI_W     = GAIN_W + SUM_W;
    localparam int DRIVE_W  = 40;
    localparam int ACC_W    = PI_W + 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = BOUND_W;

    localparam logic [CFG_IDX_W-1:0] REG_KP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SUM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_REF = 3'd4;

    // 20.0 in Q8.8
    localparam logic signed [SAMPLE_W-1:0] MIN_REF_RESET = 16'sd5120;

    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = 40'sh80_0000_0000;

    typedef struct packed {
        logic signed [GAIN_W-1:0]   kp;
        logic signed [GAIN_W-1:0]   ki;
        logic signed [GAIN_W-1:0]   kd;
        logic        [BOUND_W-1:0]  max_sum;
        logic signed [SAMPLE_W-1:0] min_ref;
    } cfg_t;

    typedef struct packed {
        logic                     skip;
        logic signed [ERR_W-1:0]  error;
        logic signed [SUM_W-1:0]  sum;
        logic signed [ERR_W-1:0]  diff;
    } upd_t;

    typedef struct packed {
        logic                    skip;
        logic signed [PD_W-1:0]  p_term;
        logic signed [PI_W-1:0]  i_term;
        logic signed [PD_W-1:0]  d_term;
    } prod_t;

endpackage

// ===== sv/pid_regulator_top.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Port group          Fields (lsb first)
// s_       in   tvalid/tready/tdata sensor[15:0], reference[31:16]
// m_       out  tvalid/tready/tdata drive[39:0]
// cfg_     in   wr_en/addr/wdata    kp, ki, kd, max_error_sum, min_reference
//
// One item per cycle while m_tready is high; stages: input reg, update, multiply, saturate.
// Integrator and previous sample update in the second stage, once per non-skipped item.
// Every stage holds its item only while the one after it is full and stalled.
// Reset clears valids, integrator and previous sample; min_reference resets to 20.0.

module pid_regulator_top
    import pid_reg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // sensor[15:0], reference[31:16]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [DRIVE_W-1:0]    m_tdata    // drive[39:0]
);

    cfg_t                       cfg_reg;
    logic                       in_valid_reg;
    logic signed [SAMPLE_W-1:0] sensor_reg;
    logic signed [SAMPLE_W-1:0] reference_reg;

    logic  upd_in_ready, upd_valid, mul_in_ready, mul_valid, sat_in_ready;
    upd_t  upd_data;
    prod_t mul_data;
    logic signed [DRIVE_W-1:0] drive;

    assign s_tready = !in_valid_reg || upd_in_ready;
    assign m_tdata  = drive;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kp      <= '0;
            cfg_reg.ki      <= '0;
            cfg_reg.kd      <= '0;
            cfg_reg.max_sum <= '0;
            cfg_reg.min_ref <= MIN_REF_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_KP:      cfg_reg.kp      <= cfg_wdata[GAIN_W-1:0];
                REG_KI:      cfg_reg.ki      <= cfg_wdata[GAIN_W-1:0];
                REG_KD:      cfg_reg.kd      <= cfg_wdata[GAIN_W-1:0];
                REG_MAX_SUM: cfg_reg.max_sum <= cfg_wdata[BOUND_W-1:0];
                REG_MIN_REF: cfg_reg.min_ref <= cfg_wdata[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            sensor_reg    <= s_tdata[SAMPLE_W-1:0];
            reference_reg <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
        end
    end

    pid_reg_upd u_upd (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (in_valid_reg),
        .in_ready  (upd_in_ready),
        .sensor    (sensor_reg),
        .reference (reference_reg),
        .out_valid (upd_valid),
        .out_ready (mul_in_ready),
        .out_data  (upd_data)
    );

    pid_reg_mul u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (upd_valid),
        .in_ready  (mul_in_ready),
        .in_data   (upd_data),
        .out_valid (mul_valid),
        .out_ready (sat_in_ready),
        .out_data  (mul_data)
    );

    pid_reg_sat u_sat (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mul_valid),
        .in_ready  (sat_in_ready),
        .in_data   (mul_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .drive     (drive)
    );

endmodule

// ===== sv/pid_reg_upd.sv =====
`timescale 1ns / 1ps

module pid_reg_upd
    import pid_reg_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  cfg_t                       cfg,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] sensor,
    input  logic signed [SAMPLE_W-1:0] reference,
    output logic                       out_valid,
    input  logic                       out_ready,
    output upd_t                       out_data
);

    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic signed [SAMPLE_W-1:0] prev_reg, prev_next;
    logic                       out_valid_reg;
    upd_t                       out_data_reg, out_data_next;

    logic                       fire;
    logic                       skip;
    logic signed [ERR_W-1:0]    error;
    logic signed [ERR_W-1:0]    diff;
    logic signed [CAND_W-1:0]   cand;
    logic        [CAND_W-1:0]   mag;

    assign in_ready  = !out_valid_reg || out_ready;
    assign fire      = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb begin
        skip  = reference < cfg.min_ref;
        error = {reference[SAMPLE_W-1], reference} - {sensor[SAMPLE_W-1], sensor};
        diff  = {prev_reg[SAMPLE_W-1], prev_reg} - {sensor[SAMPLE_W-1], sensor};
        cand  = {sum_reg[SUM_W-1], sum_reg}
              + {{(CAND_W-ERR_W){error[ERR_W-1]}}, error};
        mag   = cand[CAND_W-1] ? CAND_W'(-cand) : CAND_W'(cand);

        sum_next  = sum_reg;
        prev_next = prev_reg;
        if (fire && !skip) begin
            if (mag < {{(CAND_W-BOUND_W){1'b0}}, cfg.max_sum}) begin
                sum_next = cand[SUM_W-1:0];
            end
            prev_next = sensor;
        end

        out_data_next.skip  = skip;
        out_data_next.error = error;
        out_data_next.sum   = sum_next;
        out_data_next.diff  = diff;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            sum_reg  <= sum_next;
            prev_reg <= prev_next;
            if (in_ready) begin
                out_valid_reg <= in_valid;
            end
        end
        if (fire) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ===== sv/pid_reg_mul.sv =====
`timescale 1ns / 1ps

module pid_reg_mul
    import pid_reg_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  cfg_t  cfg,
    input  logic  in_valid,
    output logic  in_ready,
    input  upd_t  in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output prod_t out_data
);

    logic  out_valid_reg;
    prod_t out_data_reg, out_data_next;

    assign in_ready  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb begin
        out_data_next.skip   = in_data.skip;
        out_data_next.p_term = cfg.kp * in_data.error;
        out_data_next.i_term = cfg.ki * in_data.sum;
        out_data_next.d_term = cfg.kd * in_data.diff;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_ready) begin
            out_valid_reg <= in_valid;
        end
        if (in_valid && in_ready) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ===== sv/pid_reg_sat.sv =====
`timescale 1ns / 1ps

module pid_reg_sat
    import pid_reg_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  prod_t                     in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [DRIVE_W-1:0] drive
);

    logic                      out_valid_reg;
    logic signed [DRIVE_W-1:0] drive_reg, drive_next;
    logic signed [ACC_W-1:0]   acc;

    assign in_ready  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

    always_comb begin
        acc = {{(ACC_W-PD_W){in_data.p_term[PD_W-1]}}, in_data.p_term}
            + {{(ACC_W-PI_W){in_data.i_term[PI_W-1]}}, in_data.i_term}
            + {{(ACC_W-PD_W){in_data.d_term[PD_W-1]}}, in_data.d_term};
        if (in_data.skip) begin
            drive_next = '0;
        end else if (acc[ACC_W-1:DRIVE_W-1] == '0
                  || acc[ACC_W-1:DRIVE_W-1] == '1) begin
            drive_next = acc[DRIVE_W-1:0];
        end else if (acc[ACC_W-1]) begin
            drive_next = DRIVE_MIN;
        end else begin
            drive_next = DRIVE_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_ready) begin
            out_valid_reg <= in_valid;
        end
        if (in_valid && in_ready) begin
            drive_reg <= drive_next;
        end
    end

endmodule

// ===== sv/pid_reg_chk.sv =====
`timescale 1ns / 1ps

`include "pid_regulator_top_macros.svh"

module pid_reg_chk
    import pid_reg_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [DRIVE_W-1:0]    m_tdata
);

    // no result straight after reset
    `PRG_ASSERT_RST(a_rst_empty, aclk, !aresetn, !m_tvalid)

    // input only backs off when every stage is full behind a stalled output
    `PRG_ASSERT_NOW(a_ready_when_free, aclk, aresetn, !s_tready, m_tvalid && !m_tready)

    // stalled result holds
    `PRG_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata))

endmodule

bind pid_regulator_top pid_reg_chk u_chk (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import pid_reg_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 12;
    localparam int PRINT_LIMIT = 40;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = REG_MIN_REF + 3'd1;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [31:0]           s_tdata;    // sensor[15:0], reference[31:16]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [DRIVE_W-1:0]    m_tdata;    // drive[39:0]

    // predictor copy of the registers and state
    logic signed [GAIN_W-1:0]   gain_p;
    logic signed [GAIN_W-1:0]   gain_i;
    logic signed [GAIN_W-1:0]   gain_d;
    logic        [BOUND_W-1:0]  sum_bound;
    logic signed [SAMPLE_W-1:0] ref_floor;
    logic signed [SUM_W-1:0]    integ;
    logic signed [SAMPLE_W-1:0] last_sensor;

    logic [DRIVE_W-1:0] expected_drives[$];
    logic [DRIVE_W-1:0] want;
    int src_idle_pct = 15;
    int snk_idle_pct = 67;
    int fail_count = 0;
    int stall_cycles;

    pid_regulator_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    function automatic logic [DRIVE_W-1:0] next_drive(input logic signed [SAMPLE_W-1:0] sensor,
                                                      input logic signed [SAMPLE_W-1:0] reference);
        longint err, cand, mag, dif, acc;
        if (reference < ref_floor) begin
            return '0;
        end
        err  = longint'(reference) - longint'(sensor);
        cand = longint'(integ) + err;
        mag  = (cand < 0) ? -cand : cand;
        if (mag < longint'(sum_bound)) begin
            integ = cand[SUM_W-1:0];
        end
        dif = longint'(last_sensor) - longint'(sensor);
        last_sensor = sensor;
        acc = longint'(gain_p) * err + longint'(gain_i) * longint'(integ)
            + longint'(gain_d) * dif;
        if (acc > longint'(DRIVE_MAX)) begin
            acc = longint'(DRIVE_MAX);
        end
        if (acc < longint'(DRIVE_MIN)) begin
            acc = longint'(DRIVE_MIN);
        end
        return acc[DRIVE_W-1:0];
    endfunction

    function automatic logic [SAMPLE_W-1:0] to_q88(input int v);
        if (v > 32767) begin
            return 16'h7FFF;
        end
        if (v < -32768) begin
            return 16'h8000;
        end
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return '0;
            3: return to_q88(int'($urandom_range(1024)) - 512);
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    function automatic logic [BOUND_W-1:0] pick_bound();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return BOUND_W'($urandom_range(300));
            3: return BOUND_W'($urandom_range(70000));
            default: return BOUND_W'($urandom);
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_floor();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return MIN_REF_RESET;
            3: return to_q88(-int'($urandom_range(32768)));
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        if (fail_count < PRINT_LIMIT) begin
            $display("%0t: mismatch: %s", $time, what);
        end
        fail_count++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_drives.size() == 0) begin
                report_mismatch($sformatf("drive %h with no sample outstanding", m_tdata));
            end else begin
                want = expected_drives.pop_front();
                if (m_tdata !== want) begin
                    report_mismatch($sformatf("drive %h, wanted %h", m_tdata, want));
                end
            end
        end
    end

    initial begin : watchdog
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("** pid_regulator_top: FAILED **");
        $finish;
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] sensor,
                               input logic [SAMPLE_W-1:0] reference);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {reference, sensor};
        do @(posedge aclk); while (!s_tready);
        expected_drives.push_back(next_drive(sensor, reference));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_drives.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            REG_KP:      gain_p = value[GAIN_W-1:0];
            REG_KI:      gain_i = value[GAIN_W-1:0];
            REG_KD:      gain_d = value[GAIN_W-1:0];
            REG_MAX_SUM: sum_bound = value;
            REG_MIN_REF: ref_floor = value[SAMPLE_W-1:0];
            default: ;
        endcase
    endtask

    // high bits above each 16-bit field carry junk, spare index gets a random write
    task automatic load_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                              input logic [GAIN_W-1:0] kd, input logic [BOUND_W-1:0] bound,
                              input logic [SAMPLE_W-1:0] floor_q88);
        write_reg(REG_KP, {7'($urandom), kp});
        write_reg(REG_KI, {7'($urandom), ki});
        write_reg(REG_KD, {7'($urandom), kd});
        write_reg(REG_MAX_SUM, bound);
        write_reg(REG_MIN_REF, {7'($urandom), floor_q88});
        write_reg(REG_UNUSED_LO + CFG_IDX_W'($urandom_range(2)), CFG_DATA_W'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_power_on_defaults();
        send_sample(16'h0000, 16'h0000);
        send_sample(16'h1400, 16'h1400);
        send_sample(16'h8000, 16'h7FFF);
        wait_idle();
    endtask

    task automatic test_field_extremes();
        load_gains(16'h7FFF, 16'h8000, 16'h8000, 23'h7FFFFF, 16'h8000);
        send_sample(16'h8000, 16'h7FFF);
        send_sample(16'h7FFF, 16'h8000);
        send_sample(16'h7FFF, 16'h7FFF);
        send_sample(16'h8000, 16'h8000);
        send_sample(16'h0000, 16'h0000);
        send_sample(16'hFFFF, 16'hFFFF);
        wait_idle();
        load_gains(16'h8000, 16'h7FFF, 16'h7FFF, 23'h7FFFFF, 16'h8000);
        send_sample(16'h8000, 16'h7FFF);
        send_sample(16'h7FFF, 16'h8000);
        wait_idle();
    endtask

    task automatic test_reference_floor();
        load_gains(16'h0100, 16'h0100, 16'h0100, 23'h7FFFFF, 16'h0064);
        send_sample(16'h0000, 16'h0063);
        send_sample(16'h0010, 16'h0064);
        send_sample(16'h0000, 16'h8000);
        send_sample(16'h0020, 16'h7FFF);
        wait_idle();
    endtask

    // candidate equal to the bound is refused; zero bound freezes the integrator
    task automatic test_integrator_bound();
        load_gains(16'h0000, 16'h0100, 16'h0000, 23'd10, 16'h8000);
        send_sample(16'h0000, 16'h000A);
        send_sample(16'h0000, 16'h0009);
        send_sample(16'h0009, 16'h0000);
        send_sample(16'h0000, 16'hFFF6);
        wait_idle();
        load_gains(16'h0100, 16'h0100, 16'h0100, 23'd0, 16'h8000);
        send_sample(16'h0000, 16'h0001);
        send_sample(16'h0005, 16'h0000);
        wait_idle();
    endtask

    // mostly passing references with a biased error so the integrator winds up
    task automatic test_random_traffic(input int n_items, input int src_pct, input int snk_pct);
        int fl, r, s, roll, drift;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        for (int g = 0; g < 4; g++) begin
            load_gains(pick_gain(), pick_gain(), pick_gain(), pick_bound(), pick_floor());
            drift = $urandom_range(1) ? 1 : -1;
            fl = int'(ref_floor);
            for (int k = 0; k < n_items / 4; k++) begin
                roll = $urandom_range(99);
                if (roll < 70) begin
                    r = fl + int'($urandom_range(32767 - fl));
                    if ($urandom_range(1)) begin
                        s = r - drift * int'($urandom_range(32767));
                    end else begin
                        s = int'($urandom_range(65535)) - 32768;
                    end
                end else if (roll < 85 && fl > -32768) begin
                    r = -32768 + int'($urandom_range(fl + 32767));
                    s = int'($urandom_range(65535)) - 32768;
                end else begin
                    r = int'($urandom_range(65535)) - 32768;
                    s = int'($urandom_range(65535)) - 32768;
                end
                send_sample(to_q88(s), to_q88(r));
            end
            wait_idle();
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        gain_p      = '0;
        gain_i      = '0;
        gain_d      = '0;
        sum_bound   = '0;
        ref_floor   = MIN_REF_RESET;
        integ       = '0;
        last_sensor = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        test_power_on_defaults();
        test_field_extremes();
        test_reference_floor();
        test_integrator_bound();
        test_random_traffic(236, 15, 67);
        test_random_traffic(236, 67, 15);
        test_random_traffic(236, 0, 0);

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("** pid_regulator_top: PASSED **");
        end else begin
            $display("** pid_regulator_top: FAILED **");
        end
        $finish;
    end

endmodule
